// ===== rtl/mvtn_pkg.sv =====
// Shared widths, constants and handshake structs of the tone and noise mixer.
`default_nettype none

package mvtn_pkg;

   localparam int VOICES_DEFAULT = 8;

   localparam int VOL_W    = 15;
   localparam int FREQ_W   = 15;
   localparam int LEN_W    = 16;
   localparam int PER_W    = 16;
   localparam int OFS_W    = 17;
   localparam int SAMPLE_W = 19;
   localparam int LFSR_W   = 16;
   localparam int DIV_W    = 16;

   localparam logic [DIV_W-1:0]  SAMPLE_RATE = 16'd48000;
   localparam logic [LFSR_W-1:0] LFSR_SEED   = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS   = 16'hB400;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [VOL_W-1:0] volume;
      logic [LEN_W-1:0] length;
      logic [PER_W-1:0] period;
      logic [OFS_W-1:0] offset;
      logic [PER_W-1:0] phase;
      logic             wave;
   } voice_entry_type;

endpackage

`default_nettype wire

// ===== rtl/mvtn_if.sv =====
// Request and response channel interfaces of the tone and noise mixer.
`default_nettype none

interface mvtn_req_if import mvtn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [VOL_W-1:0]  volume;
   logic [FREQ_W-1:0] frequency;
   logic [LEN_W-1:0]  duration;
   logic              waveform;

   modport source (output valid, cmd, volume, frequency, duration, waveform, input ready);
   modport sink   (input valid, cmd, volume, frequency, duration, waveform, output ready);
endinterface

interface mvtn_rsp_if import mvtn_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/mvtn_div.sv =====
// Iterative restoring divider, two quotient bits per cycle.
`default_nettype none

module mvtn_div import mvtn_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEPS = DIV_W / 2;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DIV_W:0]   step_a;
   logic [DIV_W:0]   step_b;

   // Shift one dividend bit into the partial remainder; subtract when it fits.
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
                                                input logic b,
                                                input logic [DIV_W-1:0] d);
      logic [DIV_W:0]   t;
      logic [DIV_W:0]   diff;
      logic             ge;
      logic [DIV_W-1:0] rn;
      t    = {r, b};
      diff = t - {1'b0, d};
      ge   = (t >= {1'b0, d});
      rn   = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
      return {rn, ge};
   endfunction

   always_comb begin
      step_a  = div_step(rem_ff, quo_ff[DIV_W-1], dsr_ff);
      step_b  = div_step(step_a[DIV_W:1], quo_ff[DIV_W-2], dsr_ff);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = step_b[DIV_W:1];
         quo_in = {quo_ff[DIV_W-3:0], step_a[0], step_b[0]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dsr_ff  <= dsr_in;
      end
   end

   assign div_rsp = '{done: done_ff, quotient: quo_ff, remainder: rem_ff};

endmodule

`default_nettype wire

// ===== rtl/multi_voice_tone_noise_mixer_core.sv =====
// Top level of the polyphonic square and noise mixer: voice memory, sequencer, output register.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+------------------------------------------------
//   req_if   | in  | valid / ready   | cmd, volume, frequency, duration, waveform
//   rsp_if   | out | valid / ready   | sample (signed, 19 bits)
//
// One item at a time. In a sample beat each free voice is skipped over, each active voice
// is a memory read, an update and a write back, and each noise voice also waits on the
// shared divider. A play beat at frequency zero writes its voice directly; any other play
// beat first waits on the divider for the period divide.
// Synchronous reset frees every voice and seeds the noise generator; no clearing pass.
// A finished sample waits in the output register; a further sample holds at its end
// until that register is taken.
`default_nettype none

module multi_voice_tone_noise_mixer_core import mvtn_pkg::*; #(
   parameter int VOICES = VOICES_DEFAULT
) (
   input wire         clock,
   input wire         reset,
   mvtn_req_if.sink   req_if,
   mvtn_rsp_if.source rsp_if
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAY_DIV,
      ST_READ,
      ST_EVAL,
      ST_NOISE_DIV,
      ST_WRITE,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [VOICES-1:0]          active_ff, active_in;
   logic [VW-1:0]              vidx_ff, vidx_in;
   logic [LFSR_W-1:0]          lfsr_ff, lfsr_in;
   logic [SAMPLE_W-1:0]        sum_ff, sum_in;
   voice_entry_type            ent_ff, ent_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_sample_ff, rsp_sample_in;

   voice_entry_type            mem [VOICES];
   voice_entry_type            rd_data_ff;
   logic                       mem_we;
   logic [VW-1:0]              mem_waddr;
   voice_entry_type            mem_wdata;

   div_req_type                div_req;
   div_rsp_type                div_rsp;

   logic                       req_accept;
   logic [VW-1:0]              free_idx;
   logic                       free_any;
   logic                       last_voice;
   logic [LFSR_W-1:0]          lfsr_next;
   logic [OFS_W:0]             val_sq;
   logic [OFS_W-1:0]           val_noise;
   logic [PER_W-1:0]           phase_inc;

   mvtn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_accept    = req_if.valid & req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;
   assign last_voice    = (vidx_ff == VW'(VOICES - 1));

   // Lowest free voice.
   always_comb begin
      free_idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) free_idx = VW'(i);
      end
      free_any = ~&active_ff;
   end

   always_comb begin
      lfsr_next = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
      // Square: phase tracks offset mod period, so only a compare is left.
      val_sq    = (rd_data_ff.phase < (rd_data_ff.period >> 1))
                  ? {3'b000, rd_data_ff.volume}
                  : -{3'b000, rd_data_ff.volume};
      val_noise = {1'b0, div_rsp.remainder} - {2'b00, ent_ff.volume};
      phase_inc = ent_ff.phase + PER_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      vidx_in       = vidx_ff;
      lfsr_in       = lfsr_ff;
      sum_in        = sum_ff;
      ent_in        = ent_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      mem_we        = 1'b0;
      mem_waddr     = vidx_ff;
      mem_wdata     = ent_ff;
      div_req       = '{start: 1'b0, dividend: SAMPLE_RATE, divisor: '0};

      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.cmd) begin
                  if (free_any) begin
                     vidx_in       = free_idx;
                     ent_in.volume = req_if.volume;
                     ent_in.length = req_if.duration;
                     ent_in.period = PER_W'(1);
                     ent_in.offset = '0;
                     ent_in.phase  = '0;
                     ent_in.wave   = req_if.waveform;
                     if (req_if.frequency == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = free_idx;
                        mem_wdata = ent_in;
                        vidx_in   = free_idx;
                        active_in[free_idx] = (req_if.volume != '0);
                     end else begin
                        div_req.start   = 1'b1;
                        div_req.divisor = DIV_W'(req_if.frequency);
                        state_in        = ST_PLAY_DIV;
                     end
                  end
                  // drop the play beat when every voice is busy
               end else begin
                  sum_in   = '0;
                  vidx_in  = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_PLAY_DIV: begin
            if (div_rsp.done) begin
               ent_in.period      = div_rsp.quotient;
               mem_we             = 1'b1;
               mem_wdata          = ent_in;
               active_in[vidx_ff] = (ent_ff.volume != '0);
               state_in           = ST_IDLE;
            end
         end
         ST_READ: begin
            if (active_ff[vidx_ff]) begin
               state_in = ST_EVAL;
            end else if (last_voice) begin
               state_in = ST_EMIT;
            end else begin
               vidx_in = vidx_ff + VW'(1);
            end
         end
         ST_EVAL: begin
            ent_in = rd_data_ff;
            if (rd_data_ff.wave) begin
               lfsr_in          = lfsr_next;
               div_req.start    = 1'b1;
               div_req.dividend = lfsr_next;
               div_req.divisor  = {rd_data_ff.volume, 1'b0};
               state_in         = ST_NOISE_DIV;
            end else begin
               sum_in   = sum_ff + {{(SAMPLE_W - OFS_W - 1){val_sq[OFS_W]}}, val_sq};
               state_in = ST_WRITE;
            end
         end
         ST_NOISE_DIV: begin
            if (div_rsp.done) begin
               sum_in   = sum_ff
                          + {{(SAMPLE_W - OFS_W){val_noise[OFS_W-1]}}, val_noise};
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_we           = 1'b1;
            mem_wdata.offset = ent_ff.offset + OFS_W'(1);
            mem_wdata.phase  = (phase_inc == ent_ff.period) ? '0 : phase_inc;
            if (ent_ff.offset >= {1'b0, ent_ff.length}) active_in[vidx_ff] = 1'b0;
            if (last_voice) begin
               state_in = ST_EMIT;
            end else begin
               vidx_in  = vidx_ff + VW'(1);
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free or being taken
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sum_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
         vidx_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         lfsr_ff       <= lfsr_in;
         rsp_valid_ff  <= rsp_valid_in;
         vidx_ff       <= vidx_in;
         sum_ff        <= sum_in;
         ent_ff        <= ent_in;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   // Voice memory: one entry per voice. A voice is read, updated and written back
   // before the next voice is read, so accesses to one entry never overlap.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[vidx_ff];
   end

`ifndef ASSERT_OFF
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_PLAY_DIV || state_ff == ST_NOISE_DIV))
      else $error("divider finished with no state waiting on it");

   a_eval_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> active_ff[vidx_ff])
      else $error("evaluating a free voice");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("finished sample not presented");
`endif

endmodule

`default_nettype wire

// ===== sim/multi_voice_tone_noise_mixer_core_tb.sv =====
// Self-checking testbench of the tone and noise mixer core with a built-in voice predictor.
`default_nettype none

module multi_voice_tone_noise_mixer_core_tb;
   import mvtn_pkg::*;

   localparam int NUM_VOICES  = VOICES_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 200;
   localparam int CALM_FIRST  = 20000;
   localparam int CALM_LAST   = 32000;
   localparam int RANDOM_BEATS = 1530;

   typedef enum logic {CMD_SAMPLE = 1'b0, CMD_PLAY = 1'b1} mix_cmd_type;
   typedef enum logic {WAVE_SQUARE = 1'b0, WAVE_NOISE = 1'b1} wave_type;

   typedef struct {
      logic              hold;
      mix_cmd_type       cmd;
      logic [VOL_W-1:0]  volume;
      logic [FREQ_W-1:0] frequency;
      logic [LEN_W-1:0]  duration;
      wave_type          waveform;
   } mixer_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mvtn_req_if req_if();
   mvtn_rsp_if rsp_if();

   multi_voice_tone_noise_mixer_core #(.VOICES(NUM_VOICES)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mixer_beat_type      pending_beats[$];
   logic [SAMPLE_W-1:0] expected_samples[$];

   // predictor copy of the voice bank
   logic [VOL_W-1:0]  slot_level[NUM_VOICES];
   logic [LEN_W-1:0]  slot_last[NUM_VOICES];
   logic [PER_W-1:0]  slot_period_len[NUM_VOICES];
   logic [OFS_W-1:0]  slot_pos[NUM_VOICES];
   logic              slot_noise[NUM_VOICES];
   logic [LFSR_W-1:0] noise_reg;

   logic req_fire = 1'b0;
   int   cycle_count = 0;
   int   stall_cycles = 0;
   int   err_count = 0;
   logic calm;

   assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

   task automatic start_effect(input logic [VOL_W-1:0] vol, input logic [FREQ_W-1:0] freq,
                               input logic [LEN_W-1:0] dur, input logic wave);
      int slot;
      int unsigned quot;
      slot = -1;
      for (int v = 0; v < NUM_VOICES; v++)
         if (slot < 0 && slot_level[v] == '0) slot = v;
      // drop the play when every voice is busy
      if (slot >= 0) begin
         quot = (freq == '0) ? 1 : int'(SAMPLE_RATE) / int'(freq);
         slot_pos[slot]        = '0;
         slot_level[slot]      = vol;
         slot_last[slot]       = dur;
         slot_period_len[slot] = quot[PER_W-1:0];
         slot_noise[slot]      = wave;
      end
   endtask

   task automatic mix_voices(output logic [SAMPLE_W-1:0] mixed);
      int acc, part, lvl;
      int unsigned per, pos, draw;
      acc = 0;
      for (int v = 0; v < NUM_VOICES; v++) begin
         if (slot_level[v] != '0) begin
            lvl = int'(slot_level[v]);
            if (slot_noise[v]) begin
               // advance the shared generator once per active noise voice
               noise_reg = noise_reg[0] ? ((noise_reg >> 1) ^ LFSR_TAPS) : (noise_reg >> 1);
               draw = noise_reg;
               part = int'(draw % (2 * lvl)) - lvl;
            end else begin
               per = slot_period_len[v];
               if (per == 0) per = 1;
               pos = slot_pos[v];
               part = ((pos % per) < (per / 2)) ? lvl : -lvl;
            end
            acc = acc + part;
            if (slot_pos[v] >= {1'b0, slot_last[v]}) slot_level[v] = '0;
            slot_pos[v] = slot_pos[v] + OFS_W'(1);
         end
      end
      mixed = acc[SAMPLE_W-1:0];
   endtask

   task automatic add_play(input int vol, input int freq, input int dur, input wave_type wave);
      mixer_beat_type b;
      b.hold      = 1'b0;
      b.cmd       = CMD_PLAY;
      b.volume    = vol[VOL_W-1:0];
      b.frequency = freq[FREQ_W-1:0];
      b.duration  = dur[LEN_W-1:0];
      b.waveform  = wave;
      pending_beats.push_back(b);
   endtask

   task automatic add_samples(input int count);
      mixer_beat_type b;
      b.hold      = 1'b0;
      b.cmd       = CMD_SAMPLE;
      b.waveform  = wave_type'($urandom_range(0, 1));
      for (int k = 0; k < count; k++) begin
         // unused fields carry noise
         b.volume    = VOL_W'($urandom);
         b.frequency = FREQ_W'($urandom);
         b.duration  = LEN_W'($urandom);
         pending_beats.push_back(b);
      end
   endtask

   task automatic add_hold();
      mixer_beat_type b;
      b = '{hold: 1'b1, cmd: CMD_SAMPLE, volume: '0, frequency: '0, duration: '0,
            waveform: WAVE_SQUARE};
      pending_beats.push_back(b);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (pending_beats.size() > 0 && pending_beats[0].hold) begin
            // hold off until every sample has come back
            if (expected_samples.size() == 0) void'(pending_beats.pop_front());
            req_if.valid <= 1'b0;
         end else if (pending_beats.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
            req_if.cmd       <= pending_beats[0].cmd;
            req_if.volume    <= pending_beats[0].volume;
            req_if.frequency <= pending_beats[0].frequency;
            req_if.duration  <= pending_beats[0].duration;
            req_if.waveform  <= pending_beats[0].waveform;
            req_if.valid     <= 1'b1;
            void'(pending_beats.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= calm || ($urandom_range(0, 99) >= 16);
   end

   // predictor, monitor and watchdog
   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      req_fire <= req_if.valid && req_if.ready;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         for (int v = 0; v < NUM_VOICES; v++) slot_level[v] = '0;
         noise_reg = LFSR_SEED;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (req_if.cmd == CMD_PLAY) begin
               start_effect(req_if.volume, req_if.frequency, req_if.duration, req_if.waveform);
            end else begin
               mix_voices(want);
               expected_samples.push_back(want);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample beat with nothing expected, actual %0d", rsp_if.sample);
               err_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_if.sample !== want) begin
                  $error("field sample: expected %0d, actual %0d", $signed(want), rsp_if.sample);
                  err_count++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("multi_voice_tone_noise_mixer_core_tb: done, errors");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int kind, vol, freq, dur, placed;
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_SAMPLE;
      req_if.volume    = '0;
      req_if.frequency = '0;
      req_if.duration  = '0;
      req_if.waveform  = WAVE_SQUARE;
      rsp_if.ready     = 1'b0;

      // empty bank, period one, zero volume with all-ones fields
      add_samples(1);
      add_play(32767, 0, 0, WAVE_SQUARE);
      add_samples(1);
      add_play(0, 32767, 65535, WAVE_NOISE);
      // fill all voices, then one more that must be dropped
      add_play(32767, 24000, 3, WAVE_SQUARE);
      add_play(1, 1, 2, WAVE_SQUARE);
      add_play(32767, 1000, 5, WAVE_NOISE);
      add_play(1, 0, 0, WAVE_NOISE);
      add_play(16384, 440, 10, WAVE_SQUARE);
      add_play(100, 32767, 1, WAVE_SQUARE);
      add_play(5000, 12345, 4, WAVE_NOISE);
      add_play(7, 3, 2, WAVE_SQUARE);
      add_play(9, 9, 9, WAVE_NOISE);
      add_samples(4);
      add_hold();
      add_samples(8);

      placed = 0;
      while (placed < RANDOM_BEATS) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            add_samples(1);
            placed++;
         end else if (kind < 85) begin
            vol  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 32767);
            case ($urandom_range(0, 9))
               0: freq = 0;
               1: freq = $urandom_range(24001, 32767);
               default: freq = $urandom_range(1, 24000);
            endcase
            dur = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
            add_play(vol, freq, dur, wave_type'($urandom_range(0, 1)));
            placed++;
         end else if (kind < 95) begin
            add_play(0, $urandom_range(0, 32767), $urandom_range(0, 65535),
                     wave_type'($urandom_range(0, 1)));
            placed++;
         end else begin
            dur = $urandom_range(5, 20);
            add_samples(dur);
            placed += dur;
         end
         if (placed >= RANDOM_BEATS / 2 && placed < RANDOM_BEATS / 2 + 25 && kind == 0)
            add_hold();
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_beats.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (err_count == 0 && expected_samples.size() == 0)
         $display("multi_voice_tone_noise_mixer_core_tb: done, clean");
      else
         $display("multi_voice_tone_noise_mixer_core_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mvtn_pkg.sv
rtl/mvtn_if.sv
rtl/mvtn_div.sv
rtl/multi_voice_tone_noise_mixer_core.sv
sim/multi_voice_tone_noise_mixer_core_tb.sv
